// ----- src/tpasc_pkg.sv -----
// Shared types and constants for the three-phase ADC sample collector.
`default_nettype none

package tpasc_pkg;

    // Command codes carried by each input item
    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_STOP     = 2'd1,
        CMD_COMPLETE = 2'd2,
        CMD_READ     = 2'd3
    } cmd_t;

    // Status codes returned with each result item
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_ARG    = 3'd1,
        ST_BAD_STATE  = 3'd2,
        ST_SYNC_ERR   = 3'd3,
        ST_BAD_SAMPLE = 3'd4,
        ST_NOT_READY  = 3'd5,
        ST_OVERRUN    = 3'd6
    } status_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_OFFSET_A  = 3'd0,
        REG_OFFSET_B  = 3'd1,
        REG_OFFSET_C  = 3'd2,
        REG_OFFSET_DC = 3'd3,
        REG_GAIN_A    = 3'd4,
        REG_GAIN_B    = 3'd5,
        REG_GAIN_C    = 3'd6,
        REG_GAIN_DC   = 3'd7
    } reg_index_t;

    localparam int          NUM_PHASES    = 3;
    localparam logic [1:0]  PHASE_UNKNOWN = 2'd3;
    localparam logic [2:0]  FULL_MASK     = 3'b111;
    localparam int          CODE_BITS     = 16;
    localparam int          RAW_BITS      = 12;
    localparam int          OFFSET_BITS   = 16;
    localparam int          GAIN_BITS     = 32;
    localparam int          VALUE_BITS    = 40;
    localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 16'd32768;
    localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = 32'd1;

    // Decision made for one item by the control logic
    typedef struct packed {
        status_t status;
        logic    sample_complete;
        logic    read_ok;
    } ctl_res_t;

endpackage

`default_nettype wire

// ----- src/tpasc_ctrl.sv -----
// Collection state, phase code storage and per-item status decision.
`default_nettype none

module tpasc_ctrl
    import tpasc_pkg::*;
#(
    parameter int CODE_MAX = 4095,
    parameter int CODE_W   = 12
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  advance,
    input  wire logic [1:0]            cmd,
    input  wire logic [1:0]            phase_index,
    input  wire logic [CODE_BITS-1:0]  phase_code,
    input  wire logic [CODE_BITS-1:0]  dc_code,
    input  wire logic                  end_of_conversion,
    input  wire logic                  overrun_flag,
    output ctl_res_t                   res,
    output logic      [CODE_W-1:0]     phase_codes [NUM_PHASES]
);

    localparam logic [CODE_BITS-1:0] CODE_LIMIT = CODE_BITS'(CODE_MAX);

    logic              running_reg, running_next;
    logic              fault_reg, fault_next;
    logic              ready_reg, ready_next;
    logic [2:0]        mask_reg, mask_next;
    logic              code_wr;
    logic [2:0]        phase_bit;
    logic [2:0]        mask_or;
    logic [CODE_W-1:0] codes_reg [NUM_PHASES];

    assign phase_bit = 3'b001 << phase_index;
    assign mask_or   = mask_reg | phase_bit;

    // Decide status and next collection state for the item at the head
    always_comb begin
        running_next        = running_reg;
        fault_next          = fault_reg;
        ready_next          = ready_reg;
        mask_next           = mask_reg;
        code_wr             = 1'b0;
        res.status          = ST_OK;
        res.sample_complete = 1'b0;
        res.read_ok         = 1'b0;
        case (cmd)
            CMD_START: begin
                if (fault_reg) begin
                    res.status = ST_SYNC_ERR;
                end else if (!running_reg) begin
                    mask_next    = 3'b000;
                    ready_next   = 1'b0;
                    running_next = 1'b1;
                end
            end
            CMD_STOP: begin
                running_next = 1'b0;
                mask_next    = 3'b000;
                ready_next   = 1'b0;
                fault_next   = 1'b0;
            end
            CMD_COMPLETE: begin
                if (!running_reg) begin
                    res.status = ST_BAD_STATE;
                end else if (fault_reg) begin
                    res.status = ST_SYNC_ERR;
                end else if (phase_index == PHASE_UNKNOWN) begin
                    res.status = ST_BAD_ARG;
                end else if (((mask_reg & phase_bit) != 3'b000) || ready_reg) begin
                    fault_next = 1'b1;
                    ready_next = 1'b0;
                    mask_next  = 3'b000;
                    res.status = ST_SYNC_ERR;
                end else if (phase_code > CODE_LIMIT) begin
                    fault_next = 1'b1;
                    mask_next  = 3'b000;
                    res.status = ST_BAD_SAMPLE;
                end else begin
                    code_wr = 1'b1;
                    if (mask_or == FULL_MASK) begin
                        mask_next           = 3'b000;
                        ready_next          = 1'b1;
                        res.sample_complete = 1'b1;
                    end else begin
                        mask_next = mask_or;
                    end
                end
            end
            CMD_READ: begin
                if (!running_reg) begin
                    res.status = ST_BAD_STATE;
                end else if (fault_reg) begin
                    res.status = ST_SYNC_ERR;
                end else if (!ready_reg) begin
                    res.status = ST_NOT_READY;
                end else begin
                    ready_next = 1'b0;
                    if (!end_of_conversion) begin
                        res.status = ST_NOT_READY;
                    end else if (overrun_flag) begin
                        res.status = ST_OVERRUN;
                    end else if (dc_code > CODE_LIMIT) begin
                        res.status = ST_BAD_SAMPLE;
                    end else begin
                        res.read_ok = 1'b1;
                    end
                end
            end
            default: begin
                res.status = ST_OK;
            end
        endcase
    end

    // Update collection state when the item moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            fault_reg   <= 1'b0;
            ready_reg   <= 1'b0;
            mask_reg    <= 3'b000;
        end else if (advance) begin
            running_reg <= running_next;
            fault_reg   <= fault_next;
            ready_reg   <= ready_next;
            mask_reg    <= mask_next;
        end
    end

    // Store the completing phase code
    always_ff @(posedge aclk) begin
        if (advance && code_wr) begin
            codes_reg[phase_index] <= phase_code[CODE_W-1:0];
        end
    end

    assign phase_codes = codes_reg;

endmodule

`default_nettype wire

// ----- src/tpasc_scale.sv -----
// One conversion lane: offset, gain multiply, rounding and 40-bit saturation.
`default_nettype none

module tpasc_scale
    import tpasc_pkg::*;
(
    input  wire logic                          aclk,
    input  wire logic                          prod_en,
    input  wire logic                          out_en,
    input  wire logic                          keep,
    input  wire logic        [CODE_BITS-1:0]   code,
    input  wire logic        [OFFSET_BITS-1:0] offset,
    input  wire logic signed [GAIN_BITS-1:0]   gain,
    output logic signed      [VALUE_BITS-1:0]  value
);

    localparam int DIFF_W = CODE_BITS + 6;
    localparam int PROD_W = DIFF_W + GAIN_BITS;
    localparam int RND_W  = PROD_W + 1;
    localparam int SHF_W  = RND_W - 8;
    localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic signed [DIFF_W-1:0]     diff;
    logic signed [PROD_W-1:0]     prod_next;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [RND_W-1:0]      rnd;
    logic signed [SHF_W-1:0]      shf;
    logic                         fits;
    logic signed [VALUE_BITS-1:0] sat;
    logic signed [VALUE_BITS-1:0] value_reg;

    // Remove the offset (sixteenths of a count) and scale by the gain
    assign diff      = $signed({2'b00, code, 4'b0000}) - $signed({6'b000000, offset});
    assign prod_next = PROD_W'(diff) * PROD_W'(gain);

    always_ff @(posedge aclk) begin
        if (prod_en) begin
            prod_reg <= prod_next;
        end
    end

    // Round to nearest, ties up, then clamp to the signed output range
    assign rnd  = RND_W'(prod_reg) + RND_W'(128);
    assign shf  = SHF_W'(rnd >>> 8);
    assign fits = (shf[SHF_W-1:VALUE_BITS-1] == {(SHF_W-VALUE_BITS+1){1'b0}})
               || (shf[SHF_W-1:VALUE_BITS-1] == {(SHF_W-VALUE_BITS+1){1'b1}});
    assign sat  = fits ? shf[VALUE_BITS-1:0] : (shf[SHF_W-1] ? VAL_MIN : VAL_MAX);

    always_ff @(posedge aclk) begin
        if (out_en) begin
            value_reg <= keep ? sat : '0;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// ----- src/three_phase_adc_sample_collector.sv -----
// Top level: input register, control, four conversion lanes and result register.
// Throughput: one item per cycle while m_ready is not held low; the input, product and
// result registers form a three-stage pipeline that advances each stage whenever the
// next one is free.
// Reset (aresetn low, synchronous) stops collection, clears the error, mask and
// pending flags, empties the pipeline and restores offsets and gains.
`default_nettype none

module three_phase_adc_sample_collector
    import tpasc_pkg::*;
#(
    parameter int CODE_MAX = 4095
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic        [1:0]             s_cmd,
    input  wire logic        [1:0]             s_phase_index,
    input  wire logic        [CODE_BITS-1:0]   s_phase_code,
    input  wire logic        [CODE_BITS-1:0]   s_dc_code,
    input  wire logic                          s_end_of_conversion,
    input  wire logic                          s_overrun_flag,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic             [2:0]             m_status,
    output logic                               m_sample_complete,
    output logic             [RAW_BITS-1:0]    m_raw_phase_a,
    output logic             [RAW_BITS-1:0]    m_raw_phase_b,
    output logic             [RAW_BITS-1:0]    m_raw_phase_c,
    output logic             [RAW_BITS-1:0]    m_raw_dc_link,
    output logic signed      [VALUE_BITS-1:0]  m_current_a,
    output logic signed      [VALUE_BITS-1:0]  m_current_b,
    output logic signed      [VALUE_BITS-1:0]  m_current_c,
    output logic signed      [VALUE_BITS-1:0]  m_dc_voltage,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic        [2:0]             cfg_index,
    input  wire logic        [GAIN_BITS-1:0]   cfg_data
);

    localparam int CODE_W = $clog2(CODE_MAX + 1);

    // Configuration registers
    logic [OFFSET_BITS-1:0] offset_reg [4];
    logic [GAIN_BITS-1:0]   gain_reg [4];

    // Pipeline control
    logic s0_valid_reg, s1_valid_reg, m_valid_reg;
    logic out_load, s1_free, adv0, in_load;

    // Input stage
    logic [1:0]           s0_cmd_reg, s0_idx_reg;
    logic [CODE_BITS-1:0] s0_code_reg, s0_dc_reg;
    logic                 s0_eoc_reg, s0_ovr_reg;

    // Control results
    ctl_res_t          ctl_res;
    logic [CODE_W-1:0] phase_codes [NUM_PHASES];
    logic [CODE_BITS-1:0] code_a, code_b, code_c;

    // Product stage
    status_t           s1_status_reg;
    logic              s1_complete_reg, s1_ok_reg;
    logic [RAW_BITS-1:0] s1_raw_a_reg, s1_raw_b_reg, s1_raw_c_reg, s1_raw_dc_reg;

    // Result stage
    status_t           m_status_reg;
    logic              m_complete_reg;
    logic [RAW_BITS-1:0] m_raw_a_reg, m_raw_b_reg, m_raw_c_reg, m_raw_dc_reg;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                offset_reg[i] <= OFFSET_RESET;
                gain_reg[i]   <= GAIN_RESET;
            end
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_OFFSET_A:  offset_reg[0] <= cfg_data[OFFSET_BITS-1:0];
                REG_OFFSET_B:  offset_reg[1] <= cfg_data[OFFSET_BITS-1:0];
                REG_OFFSET_C:  offset_reg[2] <= cfg_data[OFFSET_BITS-1:0];
                REG_OFFSET_DC: offset_reg[3] <= cfg_data[OFFSET_BITS-1:0];
                REG_GAIN_A:    gain_reg[0]   <= cfg_data;
                REG_GAIN_B:    gain_reg[1]   <= cfg_data;
                REG_GAIN_C:    gain_reg[2]   <= cfg_data;
                REG_GAIN_DC:   gain_reg[3]   <= cfg_data;
                default:       gain_reg[3]   <= gain_reg[3];
            endcase
        end
    end

    // Advance each stage when the one after it is free or emptying
    assign out_load = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s1_free  = !s1_valid_reg || out_load;
    assign adv0     = s0_valid_reg && s1_free;
    assign s_ready  = !s0_valid_reg || adv0;
    assign in_load  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (in_load) begin
                s0_valid_reg <= 1'b1;
            end else if (adv0) begin
                s0_valid_reg <= 1'b0;
            end
            if (adv0) begin
                s1_valid_reg <= 1'b1;
            end else if (out_load) begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the incoming item
    always_ff @(posedge aclk) begin
        if (in_load) begin
            s0_cmd_reg  <= s_cmd;
            s0_idx_reg  <= s_phase_index;
            s0_code_reg <= s_phase_code;
            s0_dc_reg   <= s_dc_code;
            s0_eoc_reg  <= s_end_of_conversion;
            s0_ovr_reg  <= s_overrun_flag;
        end
    end

    tpasc_ctrl #(
        .CODE_MAX (CODE_MAX),
        .CODE_W   (CODE_W)
    ) u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .advance           (adv0),
        .cmd               (s0_cmd_reg),
        .phase_index       (s0_idx_reg),
        .phase_code        (s0_code_reg),
        .dc_code           (s0_dc_reg),
        .end_of_conversion (s0_eoc_reg),
        .overrun_flag      (s0_ovr_reg),
        .res               (ctl_res),
        .phase_codes       (phase_codes)
    );

    assign code_a = CODE_BITS'(phase_codes[0]);
    assign code_b = CODE_BITS'(phase_codes[1]);
    assign code_c = CODE_BITS'(phase_codes[2]);

    // Hold status and raw codes alongside the products
    always_ff @(posedge aclk) begin
        if (adv0) begin
            s1_status_reg   <= ctl_res.status;
            s1_complete_reg <= ctl_res.sample_complete;
            s1_ok_reg       <= ctl_res.read_ok;
            s1_raw_a_reg    <= ctl_res.read_ok ? code_a[RAW_BITS-1:0] : '0;
            s1_raw_b_reg    <= ctl_res.read_ok ? code_b[RAW_BITS-1:0] : '0;
            s1_raw_c_reg    <= ctl_res.read_ok ? code_c[RAW_BITS-1:0] : '0;
            s1_raw_dc_reg   <= ctl_res.read_ok ? s0_dc_reg[RAW_BITS-1:0] : '0;
        end
    end

    tpasc_scale u_scale_a (
        .aclk (aclk), .prod_en (adv0), .out_en (out_load), .keep (s1_ok_reg),
        .code (code_a), .offset (offset_reg[0]), .gain ($signed(gain_reg[0])),
        .value (m_current_a)
    );

    tpasc_scale u_scale_b (
        .aclk (aclk), .prod_en (adv0), .out_en (out_load), .keep (s1_ok_reg),
        .code (code_b), .offset (offset_reg[1]), .gain ($signed(gain_reg[1])),
        .value (m_current_b)
    );

    tpasc_scale u_scale_c (
        .aclk (aclk), .prod_en (adv0), .out_en (out_load), .keep (s1_ok_reg),
        .code (code_c), .offset (offset_reg[2]), .gain ($signed(gain_reg[2])),
        .value (m_current_c)
    );

    tpasc_scale u_scale_dc (
        .aclk (aclk), .prod_en (adv0), .out_en (out_load), .keep (s1_ok_reg),
        .code (s0_dc_reg), .offset (offset_reg[3]), .gain ($signed(gain_reg[3])),
        .value (m_dc_voltage)
    );

    // Load the result register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg   <= s1_status_reg;
            m_complete_reg <= s1_complete_reg;
            m_raw_a_reg    <= s1_raw_a_reg;
            m_raw_b_reg    <= s1_raw_b_reg;
            m_raw_c_reg    <= s1_raw_c_reg;
            m_raw_dc_reg   <= s1_raw_dc_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_sample_complete = m_complete_reg;
    assign m_raw_phase_a     = m_raw_a_reg;
    assign m_raw_phase_b     = m_raw_b_reg;
    assign m_raw_phase_c     = m_raw_c_reg;
    assign m_raw_dc_link     = m_raw_dc_reg;

    // A completed sample is always reported with an ok status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_complete_reg |-> m_status_reg == ST_OK)
        else $error("sample_complete with non-ok status");

    // Raw codes and values are zero unless the item is a successful read
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg != ST_OK) |->
            (m_raw_a_reg == '0) && (m_raw_dc_reg == '0) && (m_current_a == '0)
            && (m_dc_voltage == '0))
        else $error("result data on a failed item");

    // Input side stalls only while the input register is occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> s0_valid_reg && s1_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled with room in the pipeline");

    // An item that advances out of the input register must land in the product stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv0 |=> s1_valid_reg)
        else $error("product stage lost an item");

endmodule

`default_nettype wire
